### design/c16fp_pkg.sv
// Package for the CRC-16 framed packet parser: phase and status types,
// frame constants, field widths, the byte-wide CRC update and the opcode set.
// No dependencies.
`default_nettype none

package c16fp_pkg;

    // Frame constants
    localparam logic [7:0]  SYNC_BYTE_1 = 8'h55;
    localparam logic [7:0]  SYNC_BYTE_2 = 8'h66;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam int          FRAME_OVERHEAD = 10;
    localparam int          MAX_FRAME_BYTES_DEF = 1024;

    // Result payload layout, lowest bit first
    localparam int RES_BITS  = 59;
    localparam int DATA_BITS = 64;

    // Parser phase
    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CTRL,
        PH_LENL,
        PH_LENH,
        PH_SEQL,
        PH_SEQH,
        PH_OPC,
        PH_PAY,
        PH_CRCL,
        PH_CRCH
    } phase_t;

    // Verdict status
    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_HEADER,
        ST_TOO_LONG,
        ST_CRC_BAD
    } status_t;

    // Result kind carried in tuser
    typedef enum logic {
        KIND_PAYLOAD,
        KIND_VERDICT
    } kind_t;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Recognised opcode set
    function automatic logic op_known(input logic [7:0] op);
        logic k;
        case (op)
            8'h00, 8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b,
            8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15,
            8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h20, 8'h21, 8'h22, 8'h25,
            8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h30, 8'h32, 8'h33, 8'h34, 8'h35,
            8'h37, 8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3e, 8'h40, 8'h42, 8'h43,
            8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4d, 8'h4e, 8'h4f, 8'h50,
            8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h5f, 8'h60, 8'h61,
            8'h62, 8'h63, 8'h71, 8'h81, 8'h82, 8'h83, 8'hfa, 8'hfb, 8'hfc, 8'hfd,
            8'hfe:   k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### design/crc16_frame_parser.sv
// Top level of the CRC-16 framed packet parser.
// Depends on c16fp_pkg (phase/status types, CRC update, opcode set).
//
// Usage:
//   Slave stream (s_axis_*) carries one received byte per transaction.
//   Master stream (m_axis_*) carries results: tuser is the kind (0 payload
//   byte passed through, 1 frame verdict), tdata the packed result fields.
//   Frame: 55 66, control, length LE, sequence LE, opcode, payload, CRC LE
//   (CRC-16 poly 0x1021, init 0, over all bytes before the CRC).
// Path: a byte accepted from s_axis is held in the input register and
//   parsed into the result register, which drives m_axis_tvalid.
// Throughput: one byte per cycle unless a stall (below) holds it; the
//   whole parse step is a single byte CRC update, a length compare and
//   the phase decode between the input register and the result register.
// Stall: while the result register is full and m_axis_tready is low, a
//   byte that gives a result waits in the input register; bytes that give
//   no result still pass. s_axis_tready then drops once the input register
//   is occupied and cannot move.
// Reset: rst_n clears both registers' valid flags and returns the parser
//   to hunting for the first sync byte.
`default_nettype none

module crc16_frame_parser
    import c16fp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [7:0] payload_byte, [9:8] status,
                                             // [17:10] control_field,
                                             // [33:18] payload_len,
                                             // [49:34] seq_number,
                                             // [57:50] command_code,
                                             // [58] command_known, rest zero
    output logic             m_axis_tuser    // [0] kind
);

    localparam logic [17:0] MAX_TOTAL = 18'(MAX_FRAME_BYTES);
    localparam logic [17:0] OVERHEAD  = 18'(FRAME_OVERHEAD);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  opc_reg, opc_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    // Result register
    logic                 out_valid_reg;
    kind_t                out_kind_reg, out_kind_next;
    logic [DATA_BITS-1:0] out_data_reg, out_data_next;

    // Step decode
    logic        produce;
    logic        is_verdict;
    status_t     res_status;
    logic        have_op;
    logic [15:0] len_full;
    logic [15:0] idx_inc;
    logic [15:0] rx_crc;
    logic [15:0] crc_step;
    logic        fire;
    logic [7:0]  b;

    assign b        = in_byte_reg;
    assign crc_step = crc16_upd(crc_reg, b);
    assign len_full = {b, len_reg[7:0]};
    assign idx_inc  = idx_reg + 16'd1;
    assign rx_crc   = {b, crc_low_reg};

    // Handshake: parse when the byte is held and its result has somewhere to go
    assign fire          = in_valid_reg && (!produce || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    // Next phase and held fields
    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        ctrl_next    = ctrl_reg;
        len_next     = len_reg;
        seq_next     = seq_reg;
        opc_next     = opc_reg;
        crc_low_next = crc_low_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (b == SYNC_BYTE_1)
                begin
                    ctrl_next    = '0;
                    len_next     = '0;
                    seq_next     = '0;
                    opc_next     = '0;
                    crc_low_next = '0;
                    idx_next     = '0;
                    crc_next     = crc16_upd(16'h0000, b);
                    phase_next   = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (b != SYNC_BYTE_2)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    crc_next   = crc_step;
                    phase_next = PH_CTRL;
                end
            end
            PH_CTRL:
            begin
                ctrl_next  = b;
                crc_next   = crc_step;
                phase_next = PH_LENL;
            end
            PH_LENL:
            begin
                len_next   = {8'h00, b};
                crc_next   = crc_step;
                phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                len_next = len_full;
                crc_next = crc_step;
                if (({2'b00, len_full} + OVERHEAD) > MAX_TOTAL)
                    phase_next = PH_HUNT;
                else
                    phase_next = PH_SEQL;
            end
            PH_SEQL:
            begin
                seq_next   = {8'h00, b};
                crc_next   = crc_step;
                phase_next = PH_SEQH;
            end
            PH_SEQH:
            begin
                seq_next   = {b, seq_reg[7:0]};
                crc_next   = crc_step;
                phase_next = PH_OPC;
            end
            PH_OPC:
            begin
                opc_next   = b;
                crc_next   = crc_step;
                idx_next   = '0;
                phase_next = (len_reg == 16'd0) ? PH_CRCL : PH_PAY;
            end
            PH_PAY:
            begin
                crc_next = crc_step;
                idx_next = idx_inc;
                if (idx_inc >= len_reg)
                    phase_next = PH_CRCL;
            end
            PH_CRCL:
            begin
                crc_low_next = b;
                phase_next   = PH_CRCH;
            end
            PH_CRCH:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Result decode
    always_comb
    begin
        produce    = 1'b0;
        is_verdict = 1'b0;
        res_status = ST_OK;
        have_op    = 1'b0;
        case (phase_reg)
            PH_SYNC2:
            begin
                if (b != SYNC_BYTE_2)
                begin
                    produce    = 1'b1;
                    is_verdict = 1'b1;
                    res_status = ST_BAD_HEADER;
                end
            end
            PH_LENH:
            begin
                if (({2'b00, len_full} + OVERHEAD) > MAX_TOTAL)
                begin
                    produce    = 1'b1;
                    is_verdict = 1'b1;
                    res_status = ST_TOO_LONG;
                end
            end
            PH_PAY:
            begin
                produce = 1'b1;
            end
            PH_CRCH:
            begin
                produce    = 1'b1;
                is_verdict = 1'b1;
                have_op    = 1'b1;
                res_status = (rx_crc == crc_reg) ? ST_OK : ST_CRC_BAD;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase

        if (is_verdict)
        begin
            out_kind_next = KIND_VERDICT;
            out_data_next = {{(DATA_BITS - RES_BITS){1'b0}},
                             have_op && op_known(opc_reg),
                             opc_reg, seq_reg, len_next, ctrl_reg,
                             res_status, 8'h00};
        end
        else
        begin
            out_kind_next = KIND_PAYLOAD;
            out_data_next = {{(DATA_BITS - 8){1'b0}}, b};
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            if (s_axis_tvalid)
                in_byte_reg <= s_axis_tdata;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            idx_reg     <= '0;
            crc_reg     <= '0;
            ctrl_reg    <= '0;
            len_reg     <= '0;
            seq_reg     <= '0;
            opc_reg     <= '0;
            crc_low_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            ctrl_reg    <= ctrl_next;
            len_reg     <= len_next;
            seq_reg     <= seq_next;
            opc_reg     <= opc_next;
            crc_low_reg <= crc_low_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_PAYLOAD;
            out_data_reg  <= '0;
        end
        else if (fire && produce)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= out_kind_next;
            out_data_reg  <= out_data_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for crc16_frame_parser: directed frames from a table, then random
// frames, noise and broken headers, predicted by a byte-serial parser model held here.
// Depends on c16fp_pkg (phase, status and kind types, frame constants) and the RTL top.
`default_nettype none

module tb_top;
    import c16fp_pkg::*;

    localparam int FRAME_LIMIT = MAX_FRAME_BYTES_DEF;
    localparam int ALL_BYTES   = 32'h7fff_ffff;
    localparam int SMALL_BYTES = 1170;
    localparam int PRINT_CAP   = 40;

    // One result transaction, split into its fields
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        status_t     status;
        logic [7:0]  control;
        logic [15:0] len;
        logic [15:0] seq;
        logic [7:0]  opcode;
        logic        known;
    } frame_result_t;

    localparam frame_result_t NO_RES = '0;

    // Directed table: where each byte comes from and how its result is checked
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_LO_BAD} byte_src_t;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} check_t;

    typedef struct packed {
        byte_src_t     src;
        logic [7:0]    val;
        check_t        chk;
        frame_result_t want;
    } stim_row_t;

    localparam int N_DIRECTED = 29;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // idle byte while hunting is dropped
        '{SRC_LIT, 8'hFF, CHK_NONE, NO_RES},
        // sync byte followed by another sync byte: bad header, second byte consumed
        '{SRC_LIT, 8'h55, CHK_NONE, NO_RES},
        '{SRC_LIT, 8'h55, CHK_TYPED,
          '{KIND_VERDICT, 8'h00, ST_BAD_HEADER, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0}},
        // largest length field: too long, verdict at the length high byte
        '{SRC_LIT, 8'h55, CHK_NONE, NO_RES},
        '{SRC_LIT, 8'h66, CHK_NONE, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_NONE, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_NONE, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_TYPED,
          '{KIND_VERDICT, 8'h00, ST_TOO_LONG, 8'hFF, 16'hFFFF, 16'h0000, 8'h00, 1'b0}},
        // empty payload, good CRC, last opcode of the recognised set
        '{SRC_LIT, 8'h55, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h66, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'hFE, CHK_PREDICT, NO_RES},
        '{SRC_CRC_LO, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_CRC_HI, 8'h00, CHK_TYPED,
          '{KIND_VERDICT, 8'h00, ST_OK, 8'h00, 16'h0000, 16'hFFFF, 8'hFE, 1'b1}},
        // one payload byte, unknown opcode, broken CRC
        '{SRC_LIT, 8'h55, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h66, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h01, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'hFF, CHK_PREDICT, NO_RES},
        '{SRC_LIT, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_CRC_LO_BAD, 8'h00, CHK_PREDICT, NO_RES},
        '{SRC_CRC_HI, 8'h00, CHK_TYPED,
          '{KIND_VERDICT, 8'h00, ST_CRC_BAD, 8'hFF, 16'h0001, 16'h0000, 8'hFF, 1'b0}}
    };

    // Opcodes the parser flags as known
    localparam logic [7:0] KNOWN_OPS [81] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
        8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
        8'h1a, 8'h1b, 8'h20, 8'h21, 8'h22, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h30,
        8'h32, 8'h33, 8'h34, 8'h35, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3e, 8'h40,
        8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4d, 8'h4e, 8'h4f, 8'h50,
        8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h5f, 8'h60, 8'h61, 8'h62, 8'h63,
        8'h71, 8'h81, 8'h82, 8'h83, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Traffic shaping shared by both sides
    logic steady = 1'b0;
    logic hold_req = 1'b0;
    int   stall_left = 0;
    bit   hold_done = 1'b0;

    // Parser model state
    phase_t      rx_phase = PH_HUNT;
    logic [15:0] rx_count = '0;
    logic [15:0] rx_crc = '0;
    logic [7:0]  hdr_ctl = '0;
    logic [15:0] hdr_len = '0;
    logic [15:0] hdr_seq = '0;
    logic [7:0]  hdr_op = '0;
    logic [7:0]  crc_lo_seen = '0;

    frame_result_t owed_results [$];

    int err_count = 0;
    int n_bytes = 0;
    int n_payload = 0;
    int verdicts_by_status [4] = '{0, 0, 0, 0};

    crc16_frame_parser #(
        .MAX_FRAME_BYTES (FRAME_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // XMODEM CRC, one bit at a time with the input bit folded into the feedback
    function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic logic opcode_listed(input logic [7:0] op);
        foreach (KNOWN_OPS[i])
            if (KNOWN_OPS[i] == op)
                return 1'b1;
        return 1'b0;
    endfunction

    // Parser model: advance one byte, return 1 with the result when one is due
    function automatic bit parse_step(input logic [7:0] b, output frame_result_t r);
        bit      verdict;
        bit      passed;
        bit      with_op;
        status_t st;
        verdict = 1'b0;
        passed  = 1'b0;
        with_op = 1'b0;
        st      = ST_OK;
        r       = NO_RES;
        case (rx_phase)
            PH_HUNT:
                if (b == SYNC_BYTE_1)
                begin
                    hdr_ctl     = '0;
                    hdr_len     = '0;
                    hdr_seq     = '0;
                    hdr_op      = '0;
                    crc_lo_seen = '0;
                    rx_count    = '0;
                    rx_crc      = xmodem_step(16'h0000, b);
                    rx_phase    = PH_SYNC2;
                end
            PH_SYNC2:
                if (b != SYNC_BYTE_2)
                begin
                    verdict = 1'b1;
                    st      = ST_BAD_HEADER;
                end
                else
                begin
                    rx_crc   = xmodem_step(rx_crc, b);
                    rx_phase = PH_CTRL;
                end
            PH_CTRL:
            begin
                hdr_ctl  = b;
                rx_crc   = xmodem_step(rx_crc, b);
                rx_phase = PH_LENL;
            end
            PH_LENL:
            begin
                hdr_len  = {8'h00, b};
                rx_crc   = xmodem_step(rx_crc, b);
                rx_phase = PH_LENH;
            end
            PH_LENH:
            begin
                hdr_len[15:8] = b;
                rx_crc        = xmodem_step(rx_crc, b);
                if (int'(hdr_len) + FRAME_OVERHEAD > FRAME_LIMIT)
                begin
                    verdict = 1'b1;
                    st      = ST_TOO_LONG;
                end
                else
                    rx_phase = PH_SEQL;
            end
            PH_SEQL:
            begin
                hdr_seq  = {8'h00, b};
                rx_crc   = xmodem_step(rx_crc, b);
                rx_phase = PH_SEQH;
            end
            PH_SEQH:
            begin
                hdr_seq[15:8] = b;
                rx_crc        = xmodem_step(rx_crc, b);
                rx_phase      = PH_OPC;
            end
            PH_OPC:
            begin
                hdr_op   = b;
                rx_crc   = xmodem_step(rx_crc, b);
                rx_count = '0;
                rx_phase = (hdr_len == 16'h0000) ? PH_CRCL : PH_PAY;
            end
            PH_PAY:
            begin
                rx_crc   = xmodem_step(rx_crc, b);
                rx_count = rx_count + 16'd1;
                if (rx_count >= hdr_len)
                    rx_phase = PH_CRCL;
                passed    = 1'b1;
                r.kind    = KIND_PAYLOAD;
                r.payload = b;
            end
            PH_CRCL:
            begin
                crc_lo_seen = b;
                rx_phase    = PH_CRCH;
            end
            PH_CRCH:
            begin
                verdict = 1'b1;
                with_op = 1'b1;
                st      = ({b, crc_lo_seen} == rx_crc) ? ST_OK : ST_CRC_BAD;
            end
            default:
                rx_phase = PH_HUNT;
        endcase
        if (verdict)
        begin
            r = '{KIND_VERDICT, 8'h00, st, hdr_ctl, hdr_len, hdr_seq, hdr_op,
                  with_op && opcode_listed(hdr_op)};
            rx_phase = PH_HUNT;
        end
        return verdict || passed;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
                     got, want);
    endtask

    // Compare one accepted result transaction with the oldest owed result
    task automatic check_result(input logic kind_bit, input logic [63:0] d);
        frame_result_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch("unexpected result", d, 64'h0);
            return;
        end
        want = owed_results.pop_front();
        if (kind_bit != want.kind)
            report_mismatch("kind", 64'(kind_bit), 64'(want.kind));
        if (d[7:0] != want.payload)
            report_mismatch("payload_byte", 64'(d[7:0]), 64'(want.payload));
        if (d[9:8] != want.status)
            report_mismatch("status", 64'(d[9:8]), 64'(want.status));
        if (d[17:10] != want.control)
            report_mismatch("control_field", 64'(d[17:10]), 64'(want.control));
        if (d[33:18] != want.len)
            report_mismatch("payload_len", 64'(d[33:18]), 64'(want.len));
        if (d[49:34] != want.seq)
            report_mismatch("seq_number", 64'(d[49:34]), 64'(want.seq));
        if (d[57:50] != want.opcode)
            report_mismatch("command_code", 64'(d[57:50]), 64'(want.opcode));
        if (d[58] != want.known)
            report_mismatch("command_known", 64'(d[58]), 64'(want.known));
        if (d[63:59] != 5'b0)
            report_mismatch("tdata padding", 64'(d[63:59]), 64'h0);
        if (want.kind == KIND_PAYLOAD)
            n_payload++;
        else
            verdicts_by_status[want.status]++;
    endtask

    // Offer one byte and wait for its transaction, with random idle cycles first
    task automatic offer_byte(input logic [7:0] b);
        steady <= (n_bytes >= 250 && n_bytes < 450);
        if (n_bytes >= 800)
            hold_req <= 1'b1;
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_bytes++;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        frame_result_t r;
        if (parse_step(b, r))
            owed_results.push_back(r);
        offer_byte(b);
    endtask

    // Build a frame with random content; keep cuts it short, flip breaks the CRC
    task automatic send_frame(input logic [15:0] len, input bit flip, input int keep);
        logic [7:0]  q [$];
        logic [7:0]  ctl;
        logic [7:0]  op;
        logic [15:0] seq;
        logic [15:0] crc;
        ctl = 8'($urandom);
        seq = 16'($urandom);
        op  = $urandom_range(0, 1) ? KNOWN_OPS[$urandom_range(0, 80)] : 8'($urandom);
        q   = {SYNC_BYTE_1, SYNC_BYTE_2, ctl, len[7:0], len[15:8], seq[7:0], seq[15:8], op};
        // payload only matters when the frame goes past its header
        if (keep > 8)
        begin
            for (int i = 0; i < int'(len); i++)
                q.push_back(8'($urandom));
            crc = 16'h0000;
            foreach (q[i])
                crc = xmodem_step(crc, q[i]);
            q.push_back(crc[7:0]);
            q.push_back(crc[15:8]);
            if (flip)
                q[q.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < q.size() && i < keep; i++)
            feed_byte(q[i]);
    endtask

    // Receiver: check each result transaction, stall at random, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tuser, m_axis_tdata);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                stall_left = 300;
                hold_done  = 1'b1;
            end
            else
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    // Stimulus: reset, directed table, random traffic, drain and verdict
    initial
    begin
        frame_result_t r;
        logic [7:0]    b;
        int            pick;
        int            len;
        bit            big_done;
        big_done = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED[i])
        begin
            case (DIRECTED[i].src)
                SRC_CRC_LO:     b = rx_crc[7:0];
                SRC_CRC_HI:     b = rx_crc[15:8];
                SRC_CRC_LO_BAD: b = ~rx_crc[7:0];
                default:        b = DIRECTED[i].val;
            endcase
            if (parse_step(b, r) && DIRECTED[i].chk == CHK_PREDICT)
                owed_results.push_back(r);
            if (DIRECTED[i].chk == CHK_TYPED)
                owed_results.push_back(DIRECTED[i].want);
            offer_byte(b);
        end

        // random traffic, mostly well-formed frames with random content
        while (n_bytes < N_DIRECTED + SMALL_BYTES)
        begin
            if (!big_done && n_bytes >= 100)
            begin
                big_done = 1'b1;
                send_frame(16'(FRAME_LIMIT - FRAME_OVERHEAD), 1'b0, ALL_BYTES);
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
                send_frame(16'(len), $urandom_range(0, 99) < 15, ALL_BYTES);
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 2))
                    0:       len = FRAME_LIMIT - FRAME_OVERHEAD + 1;
                    1:       len = 65535;
                    default: len = $urandom_range(FRAME_LIMIT - FRAME_OVERHEAD + 1, 65535);
                endcase
                send_frame(16'(len), 1'b0, 5);
            end
            else if (pick < 86)
            begin
                b = 8'($urandom);
                if (b == SYNC_BYTE_2)
                    b = SYNC_BYTE_1;
                feed_byte(SYNC_BYTE_1);
                feed_byte(b);
            end
            else if (pick < 94)
            begin
                repeat ($urandom_range(1, 4))
                    feed_byte(8'($urandom));
            end
            else
            begin
                // frame cut short; the following bytes land inside it
                len = $urandom_range(0, 6);
                send_frame(16'(len), 1'b0, $urandom_range(1, len + 9));
            end
        end
        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;

        // drain, then give a stray result time to show up
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d bytes in, one maximum-length frame and a %0d-cycle output stall.",
                 n_bytes, 300);
        $display("Results: %0d payload, %0d ok, %0d bad header, %0d too long, %0d crc mismatch.",
                 n_payload, verdicts_by_status[ST_OK], verdicts_by_status[ST_BAD_HEADER],
                 verdicts_by_status[ST_TOO_LONG], verdicts_by_status[ST_CRC_BAD]);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still owed.", owed_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
